// ----- hdl/framed_packet_parser_crc16_assert.svh -----
// Assertion macros shared by the parser's checker.
`ifndef FRAMED_PACKET_PARSER_CRC16_ASSERT_SVH
`define FRAMED_PACKET_PARSER_CRC16_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpp assertion failed");

`endif

// ----- hdl/fpp_pkg.sv -----
// Package: types, constants and register map of the framed packet parser.
package fpp_pkg;

  // Frame buffer size default and frame layout
  localparam int          FRAME_BUFFER_BYTES_DEF = 128;
  localparam int          FRAME_OVERHEAD         = 10;
  localparam logic [15:0] CRC_POLY               = 16'h1021;

  // Configuration reset values
  localparam logic [7:0]  PRE1_RST = 8'h55;
  localparam logic [7:0]  PRE2_RST = 8'h66;
  localparam logic [15:0] SEED_RST = 16'h0000;

  // Port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  // Register index (paddr[3:2])
  localparam logic [1:0] REG_PRE1 = 2'd0;
  localparam logic [1:0] REG_PRE2 = 2'd1;
  localparam logic [1:0] REG_SEED = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_DATA  = 2'd2
  } phase_e;

endpackage

// ----- hdl/fpp_crc16_byte.sv -----
// Bytewise CRC-16 update, MSB first.
module fpp_crc16_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);
  import fpp_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {data_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

// ----- hdl/framed_packet_parser_crc16.sv -----
// Top level: byte stream framer with preamble hunt and CRC-16 check.
//
// Usage
//   s_axis: one received byte per beat (tdata[7:0]).
//   m_axis: one beat per frame byte taken after the preamble, or one beat
//           for a byte that overflows the frame buffer (tuser[1]=aborted).
//           Preamble bytes and bytes dropped while hunting give no beat.
//   APB:    preamble_first @0x0, preamble_second @0x4, crc_seed @0x8.
//           Write only while the stream is idle; pready is always high.
// Timing
//   Input register -> combinational parse/CRC step -> output register.
//   A byte sits in the input register, then its beat in the output register.
//   One byte per cycle sustained unless a beat stalls; the bytewise
//   CRC update sits between the two registers and sets the cycle time.
// Reset
//   Both stages empty, parser hunting the first preamble byte, registers
//   back to 0x55 / 0x66 / 0x0000. No clearing pass.
// Stall
//   A stalled output beat holds; the input stage still drains bytes that
//   give no beat, and only backs up when a beat has nowhere to go.
module framed_packet_parser_crc16 #(
  parameter int FRAME_BUFFER_BYTES = fpp_pkg::FRAME_BUFFER_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Byte stream in
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [fpp_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // [7:0] rx_byte
  // Frame byte stream out
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [7:0] frame_byte, [14:8] byte_index, [30:15] payload_length, [31] zero
  output logic [fpp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o,   // end_of_frame
  output logic [fpp_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,   // [0] crc_ok, [1] aborted
  // Configuration
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [fpp_pkg::APB_ADDR_W-1:0]     paddr_i,
  input  logic [fpp_pkg::APB_DATA_W-1:0]     pwdata_i,
  output logic [fpp_pkg::APB_DATA_W-1:0]     prdata_o,
  output logic                               pready_o
);
  import fpp_pkg::*;

  localparam int             CNT_W    = $clog2(FRAME_BUFFER_BYTES);
  localparam int             IDX_W    = 17;  // holds any index and length + overhead
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BUFFER_BYTES - 1);
  localparam logic [IDX_W-1:0] OVH_M2   = IDX_W'(FRAME_OVERHEAD - 2);
  localparam logic [IDX_W-1:0] OVH_M1   = IDX_W'(FRAME_OVERHEAD - 1);
  localparam logic [IDX_W-1:0] IDX_LEN_LO = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_LEN_HI = IDX_W'(4);
  localparam logic [CNT_W-1:0] CNT_FIRST  = CNT_W'(2);  // first byte after preamble

  // ---------------------------------------------------------------- config
  logic [7:0]  pre1_q, pre2_q;
  logic [15:0] seed_q;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre1_q <= PRE1_RST;
      pre2_q <= PRE2_RST;
      seed_q <= SEED_RST;
    end else if (cfg_wr) begin
      case (paddr_i[3:2])
        REG_PRE1: pre1_q <= pwdata_i[7:0];
        REG_PRE2: pre2_q <= pwdata_i[7:0];
        REG_SEED: seed_q <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      REG_PRE1: prdata_o = {24'h0, pre1_q};
      REG_PRE2: prdata_o = {24'h0, pre2_q};
      REG_SEED: prdata_o = {16'h0, seed_q};
      default:  prdata_o = '0;
    endcase
  end

  // ---------------------------------------------------------- input stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       s_acc, advance, emit, out_free;

  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;
  assign advance         = in_vld_q && (!emit || out_free);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_acc) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // --------------------------------------------------------- parser state
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_lo_q, crc_lo_d;

  logic [15:0]      crc_base, crc_new, len_new, len_out;
  logic [IDX_W-1:0] idx, tot_m2, tot_m1;
  logic             eof, ok, abort;

  // Hunt for first byte restarts from the seed; otherwise extend the running CRC
  assign crc_base = (phase_q == PH_DATA || phase_q == PH_HUNT2) ? crc_q : seed_q;

  fpp_crc16_byte u_crc (
    .crc_i  (crc_base),
    .data_i (in_byte_q),
    .crc_o  (crc_new)
  );

  assign idx     = IDX_W'(cnt_q);
  assign len_new = (idx == IDX_LEN_HI) ? {in_byte_q, crc_lo_q} : len_q;
  assign tot_m2  = IDX_W'(len_new) + OVH_M2;
  assign tot_m1  = IDX_W'(len_new) + OVH_M1;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    emit     = 1'b0;
    eof      = 1'b0;
    ok       = 1'b0;
    abort    = 1'b0;
    len_out  = len_q;
    case (phase_q)
      PH_HUNT2: begin
        if (in_byte_q == pre2_q) begin
          crc_d   = crc_new;
          len_d   = '0;
          cnt_d   = CNT_FIRST;
          phase_d = PH_DATA;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
      PH_DATA: begin
        emit = 1'b1;
        if (idx >= IDX_LAST) begin
          // buffer full: report and drop the byte
          abort   = 1'b1;
          phase_d = PH_HUNT1;
        end else begin
          len_d   = len_new;
          len_out = len_new;
          if (idx == IDX_LEN_LO) begin
            crc_lo_d = in_byte_q;  // length low byte parked until byte 4
          end
          if (idx < tot_m2) begin
            crc_d = crc_new;
          end else if (idx == tot_m2) begin
            crc_lo_d = in_byte_q;
          end
          if (idx == tot_m1) begin
            eof = 1'b1;
            ok  = ({in_byte_q, crc_lo_q} == crc_q);
          end
          if (idx >= tot_m1) begin
            phase_d = PH_HUNT1;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
        cnt_d = '0;
        if (in_byte_q == pre1_q) begin
          crc_d   = crc_new;
          phase_d = PH_HUNT2;
        end else begin
          crc_d   = seed_q;
          phase_d = PH_HUNT1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT1;
      cnt_q    <= '0;
      len_q    <= '0;
      crc_q    <= SEED_RST;
      crc_lo_q <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // --------------------------------------------------------- output stage
  logic        out_vld_q;
  logic [7:0]  out_byte_q;
  logic [6:0]  out_idx_q;
  logic [15:0] out_len_q;
  logic        out_eof_q, out_ok_q, out_abort_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_byte_q  <= in_byte_q;
      out_idx_q   <= idx[6:0];
      out_len_q   <= len_out;
      out_eof_q   <= eof;
      out_ok_q    <= ok;
      out_abort_q <= abort;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_len_q, out_idx_q, out_byte_q};
  assign m_axis_tlast_o  = out_eof_q;
  assign m_axis_tuser_o  = {out_abort_q, out_ok_q};

endmodule

// ----- hdl/fpp_checker.sv -----
// Port-level checker for the framed packet parser, bound to the top level.
`include "framed_packet_parser_crc16_assert.svh"

module fpp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [fpp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tlast_o,
  input logic [fpp_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);
  import fpp_pkg::*;

  // Stalled output beat keeps its payload
  `FPP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))

  // An aborted byte never closes a frame
  `FPP_ASSERT_SAME(a_abort_not_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[1], !m_axis_tlast_o && !m_axis_tuser_o[0])

  // CRC pass only reported on the final byte
  `FPP_ASSERT_SAME(a_ok_on_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tlast_o)

  // Pad bit of tdata stays clear
  `FPP_ASSERT_SAME(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o, !m_axis_tdata_o[OUT_TDATA_W-1])

endmodule

bind framed_packet_parser_crc16 fpp_checker u_fpp_checker (.*);

// ----- bench/fpp_frame_checker.sv -----
// Frame checker: predicts every result beat of the parser and compares it with m_axis.
module fpp_frame_checker #(
  parameter int FRAME_BUFFER_BYTES = fpp_pkg::FRAME_BUFFER_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [fpp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [fpp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                            m_axis_tlast_i,
  input  logic [fpp_pkg::OUT_TUSER_W-1:0] m_axis_tuser_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [fpp_pkg::APB_ADDR_W-1:0]  paddr_i,
  input  logic [fpp_pkg::APB_DATA_W-1:0]  pwdata_i,
  input  logic                            pready_i,
  output int                              pending_o,
  output int                              errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpp_pkg::*;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [6:0]  byte_index;
    logic [15:0] payload_length;
    logic        end_of_frame;
    logic        crc_ok;
    logic        aborted;
  } frame_beat_t;

  frame_beat_t expected_beats[$];
  frame_beat_t want;
  int          mism;

  // config copy
  logic [7:0]  pre1_q, pre2_q;
  logic [15:0] seed_q;

  // parser state
  phase_e      hunt_phase;
  int unsigned frame_pos;
  logic [15:0] len_field;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo_hold;

  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] want_v,
                                    input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    frame_beat_t e;
    int unsigned total;
    if (hunt_phase == PH_HUNT2) begin
      // wrong second byte is dropped outright, no retry as a first byte
      if (b == pre2_q) begin
        crc_acc    = crc16_add(crc_acc, b);
        len_field  = '0;
        frame_pos  = 2;
        hunt_phase = PH_DATA;
      end else begin
        hunt_phase = PH_HUNT1;
      end
    end else if (hunt_phase != PH_DATA) begin
      frame_pos  = 0;
      crc_acc    = seed_q;
      hunt_phase = PH_HUNT1;
      if (b == pre1_q) begin
        crc_acc    = crc16_add(seed_q, b);
        hunt_phase = PH_HUNT2;
      end
    end else begin
      e            = '0;
      e.frame_byte = b;
      e.byte_index = frame_pos[6:0];
      if (frame_pos >= FRAME_BUFFER_BYTES - 1) begin
        // overflow: byte reported and discarded
        e.payload_length = len_field;
        e.aborted        = 1'b1;
        hunt_phase       = PH_HUNT1;
      end else begin
        if (frame_pos == 4) len_field = {b, crc_lo_hold};
        if (frame_pos == 3) crc_lo_hold = b;
        total = 32'(len_field) + FRAME_OVERHEAD;
        if (frame_pos < total - 2) crc_acc = crc16_add(crc_acc, b);
        else if (frame_pos == total - 2) crc_lo_hold = b;
        if (frame_pos == total - 1) begin
          e.end_of_frame = 1'b1;
          e.crc_ok       = ({b, crc_lo_hold} == crc_acc);
        end
        frame_pos = frame_pos + 1;
        if (frame_pos >= total) begin
          hunt_phase = PH_HUNT1;
          frame_pos  = 0;
        end
        e.payload_length = len_field;
      end
      expected_beats.push_back(e);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre1_q      = PRE1_RST;
      pre2_q      = PRE2_RST;
      seed_q      = SEED_RST;
      hunt_phase  = PH_HUNT1;
      frame_pos   = 0;
      len_field   = '0;
      crc_acc     = SEED_RST;
      crc_lo_hold = '0;
      expected_beats.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      mism = 0;
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_PRE1: pre1_q = pwdata_i[7:0];
          REG_PRE2: pre2_q = pwdata_i[7:0];
          REG_SEED: seed_q = pwdata_i[15:0];
          default: ;
        endcase
      end
      // drain before predict: a beat never belongs to the byte taken this edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no byte pending: tdata 0x%0h", m_axis_tdata_i);
          mism++;
        end else begin
          want = expected_beats.pop_front();
          mism += field_diff("frame_byte", 32'(want.frame_byte),
                             32'(m_axis_tdata_i[7:0]));
          mism += field_diff("byte_index", 32'(want.byte_index),
                             32'(m_axis_tdata_i[14:8]));
          mism += field_diff("payload_length", 32'(want.payload_length),
                             32'(m_axis_tdata_i[30:15]));
          mism += field_diff("tdata_pad", 32'(0), 32'(m_axis_tdata_i[31]));
          mism += field_diff("end_of_frame", 32'(want.end_of_frame),
                             32'(m_axis_tlast_i));
          mism += field_diff("crc_ok", 32'(want.crc_ok), 32'(m_axis_tuser_i[0]));
          mism += field_diff("aborted", 32'(want.aborted), 32'(m_axis_tuser_i[1]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) parse_rx_byte(s_axis_tdata_i[7:0]);
      pending_o <= expected_beats.size();
      errors_o  <= errors_o + mism;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Bench top: clock, reset, byte and register stimulus, and the final verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fpp_pkg::*;

  // Cycles to let the two-stage pipe empty once every result is in
  localparam int DRAIN_CYCLES  = 8;
  // Long receiver hold-off that backs the parser up into its input
  localparam int HOLD_CYCLES   = 300;
  // Byte budget of each random phase
  localparam int PHASE_BYTES   = 200;
  localparam int RANDOM_PHASES = 8;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int pending;      // result beats still owed by the block
  int errors;       // mismatches seen by the checker

  // Idling knobs: percent chance per cycle
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;

  // Long hold-off: stimulus bumps hold_reqs, receiver serves it
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Register values as last written, used to build frames
  logic [7:0]  cur_pre1 = PRE1_RST;
  logic [7:0]  cur_pre2 = PRE2_RST;
  logic [15:0] cur_seed = SEED_RST;

  int unsigned n_sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  framed_packet_parser_crc16 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),    // [7:0] rx_byte
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    // [7:0] frame_byte, [14:8] byte_index, [30:15] payload_length, [31] zero
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),    // end_of_frame
    .m_axis_tuser_o  (m_axis_tuser),    // [0] crc_ok, [1] aborted
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  fpp_frame_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .m_axis_tuser_i  (m_axis_tuser),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  // Receiver: random stalls, or a long counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      m_axis_tready <= 1'b0;
      hold_served   <= hold_served + 1;
      hold_left     <= HOLD_CYCLES - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // CRC used only to give generated frames a matching trailer
  function automatic logic [15:0] frame_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // One input beat; random idle cycles ahead of it, tvalid left high after accept
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
  endtask

  // Frame with current preambles and seed. Oversized lengths run up to three
  // bytes past the abort point. cut limits how many bytes go out (truncated frame).
  task automatic send_frame(input logic [15:0] plen, input bit corrupt, input int unsigned cut);
    logic [7:0]  fb[$];
    logic [15:0] c;
    int unsigned total;
    int unsigned body;
    total = 32'(plen) + FRAME_OVERHEAD;
    body  = (total > FRAME_BUFFER_BYTES_DEF - 1) ? FRAME_BUFFER_BYTES_DEF - 2 + $urandom_range(3)
                                                 : total - 2;
    fb = {cur_pre1, cur_pre2, 8'($urandom_range(255)), plen[7:0], plen[15:8]};
    while (fb.size() < body) fb.push_back(8'($urandom_range(255)));
    c = cur_seed;
    foreach (fb[i]) c = frame_crc_byte(c, fb[i]);
    if (corrupt) c ^= 16'(1 << $urandom_range(15));
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    for (int i = 0; i < fb.size() && i < cut; i++) send_byte(fb[i]);
  endtask

  // Stop offering bytes and wait for every owed beat plus pipe drain
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, then psel dropped low before the task returns
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [7:0] p1, input logic [7:0] p2, input logic [15:0] sd);
    reg_write(REG_PRE1, 32'(p1));
    reg_write(REG_PRE2, 32'(p2));
    reg_write(REG_SEED, 32'(sd));
    cur_pre1 = p1;
    cur_pre2 = p2;
    cur_seed = sd;
  endtask

  initial begin
    int unsigned start;
    int          pick;
    int          lp;
    logic [15:0] plen;
    logic [7:0]  bad;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset config, no idling: byte extremes while hunting,
    // a minimal good frame, a bad second preamble byte equal to the first
    // (dropped, not taken as a new start), then a minimal frame with bad CRC.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'd0, 1'b0, 1000);
    send_byte(cur_pre1);
    send_byte(cur_pre1);
    send_frame(16'd0, 1'b1, 1000);
    quiesce();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 5)
        0: apply_setting(8'h00, 8'hFF, 16'h0000);
        1: apply_setting(8'hFF, 8'h00, 16'hFFFF);
        2: apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                         16'($urandom_range(65535)));
        3: apply_setting(8'h5A, 8'h5A, 16'($urandom_range(65535)));   // equal preambles
        default: apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                               16'($urandom_range(65535)));
      endcase
      case (p % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_gap_pct = 87; rx_stall_pct <= 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct <= 87; end
        default: begin tx_gap_pct = 12; rx_stall_pct <= 12; end
      endcase

      start = n_sent;
      if (p == 4) begin
        // Receiver holds off while full-size, just-over and huge frames pour in
        hold_reqs <= hold_reqs + 1;
        send_frame(16'd117, 1'b0, 1000);
        send_frame(16'd118, 1'b0, 1000);
        send_frame(16'hFFFF, 1'b1, 1000);
      end

      while (n_sent - start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          // well-formed frame, mostly short; some long, a few overflowing
          lp = $urandom_range(99);
          if (lp < 88)      plen = 16'($urandom_range(24));
          else if (lp < 97) plen = 16'($urandom_range(117, 90));
          else              plen = 16'($urandom_range(65535, 118));
          send_frame(plen, ($urandom_range(99) < 20), 1000);
        end else if (pick < 82) begin
          repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
        end else if (pick < 91) begin
          // broken preamble
          bad = 8'($urandom_range(255));
          if (bad == cur_pre2) bad = ~bad;
          send_byte(cur_pre1);
          send_byte(bad);
        end else begin
          // truncated frame; whatever follows is taken as its tail
          send_frame(16'($urandom_range(24)), 1'b0, $urandom_range(12, 3));
        end
      end
      quiesce();
    end

    if (errors == 0 && pending == 0) begin
      $display("framed_packet_parser_crc16 test passed");
    end else begin
      $display("framed_packet_parser_crc16 test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("framed_packet_parser_crc16 test failed");
    $finish;
  end

endmodule
